@@ rtl/qpm_pkg.sv @@
// ----------------------------------------------------------------------------
// qpm_pkg
// Shared types, register codes and mask helpers for the QR module placement
// and masking block.
// ----------------------------------------------------------------------------
package qpm_pkg;

  localparam int MaxVersionDef = 40;
  localparam int MaxAlignDef   = 7;
  localparam int VERSION_W     = 6;
  localparam int MASK_W        = 4;
  localparam int COORD_W       = 8;
  localparam int CW_W          = 12;
  localparam int ALIGN_W       = 56;
  localparam int ACNT_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERSION      = 3'd0,
    CFG_MASK_PATTERN = 3'd1,
    CFG_DATA_CW      = 3'd2,
    CFG_TOTAL_CW     = 3'd3,
    CFG_BLANK_DATA   = 3'd4,
    CFG_ALIGN_COORDS = 3'd5,
    CFG_ALIGN_COUNT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ZONE_DATA = 2'd0,
    ZONE_ECC  = 2'd1,
    ZONE_REM  = 2'd2
  } zone_t;

  localparam logic [MASK_W-1:0] MASK_P0 = 4'd0;
  localparam logic [MASK_W-1:0] MASK_P1 = 4'd1;
  localparam logic [MASK_W-1:0] MASK_P2 = 4'd2;
  localparam logic [MASK_W-1:0] MASK_P3 = 4'd3;
  localparam logic [MASK_W-1:0] MASK_P4 = 4'd4;
  localparam logic [MASK_W-1:0] MASK_P5 = 4'd5;
  localparam logic [MASK_W-1:0] MASK_P6 = 4'd6;
  localparam logic [MASK_W-1:0] MASK_P7 = 4'd7;

  typedef struct packed {
    logic [VERSION_W-1:0] version;
    logic [MASK_W-1:0]    mask_pattern;
    logic [CW_W-1:0]      data_codewords;
    logic [CW_W-1:0]      total_codewords;
    logic                 blank_data;
    logic [ALIGN_W-1:0]   alignment_coords;
    logic [ACNT_W-1:0]    alignment_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bits;
    zone_t      zone;
  } item_t;

  typedef struct packed {
    logic               is_func;
    logic [COORD_W-1:0] side;
  } fmap_t;

  // 8-bit value mod 3: base-4 digits sum, folded twice
  function automatic logic [1:0] mod3_8(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    u = (t >= 3'd3) ? (t - 3'd3) : t;
    mod3_8 = (u == 3'd3) ? 2'd0 : u[1:0];
  endfunction

  function automatic logic mask_bit(input logic [MASK_W-1:0] m,
                                    input logic [7:0] x,
                                    input logic [7:0] y);
    logic [1:0]  mx;
    logic [1:0]  my;
    logic [2:0]  sm;
    logic [1:0]  sxy;
    logic        p2;
    logic [1:0]  p3;
    logic [15:0] prod;
    logic        par;
    mx   = mod3_8(x);
    my   = mod3_8(y);
    sm   = 3'(mx) + 3'(my);
    sxy  = (sm >= 3'd3) ? 2'(sm - 3'd3) : sm[1:0];
    p2   = x[0] & y[0];
    p3   = (mx == 2'd0 || my == 2'd0) ? 2'd0 : ((mx == my) ? 2'd1 : 2'd2);
    prod = 16'(x) * 16'd171;  // bit 9 is parity of x/3
    par  = x[0] ^ y[0];
    unique case (m)
      MASK_P0: mask_bit = !par;
      MASK_P1: mask_bit = !y[0];
      MASK_P2: mask_bit = (mx == 2'd0);
      MASK_P3: mask_bit = (sxy == 2'd0);
      MASK_P4: mask_bit = !(y[1] ^ prod[9]);
      MASK_P5: mask_bit = !p2 && (p3 == 2'd0);
      MASK_P6: mask_bit = !(p2 ^ p3[0]);
      MASK_P7: mask_bit = !(p3[0] ^ par);
      default: mask_bit = 1'b0;
    endcase
  endfunction

endpackage

@@ rtl/qr_module_placement_mask.sv @@
// ----------------------------------------------------------------------------
// qr_module_placement_mask
// QR data module placement and masking.
//
// Input stream: one codeword byte per transaction on in_tdata[7:0]. Each byte
// yields up to eight module transactions on the out_ stream, one per bit,
// MSB first, with column, row, masked dark value and zone in out_tdata,
// last_of_run on out_tlast and matrix_done on out_tuser. Once the final data
// module has gone out, further bytes are taken and dropped.
// Configuration: cfg_we writes register cfg_index with cfg_wdata; write only
// while the block is idle.
// Throughput: the walker tests one candidate module per cycle unless a stalled
// receiver holds it. For each byte it picks the byte up from the queue, steps
// to its first data module and then places one module at a time, skipping
// function modules that lie in the way.
// A two-entry queue lets the input keep going while the walker works or the
// output is stalled; a stalled receiver holds the walker, and the input
// stalls once the queue is full.
// Reset (rst_n low, synchronous) restores register defaults, empties the
// queue and rewinds the walk to the lower right corner.
// ----------------------------------------------------------------------------
module qr_module_placement_mask
  import qpm_pkg::*;
#(
  parameter int MAX_VERSION      = MaxVersionDef,
  parameter int MAX_ALIGN_COORDS = MaxAlignDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ALIGN_W-1:0]     cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] codeword
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] column, [15:8] row, [16] dark,
                                             // [18:17] zone, zeros above
  output logic                   out_tlast,  // last_of_run
  output logic                   out_tuser   // matrix_done
);

  cfg_t  cfg_r;
  logic  q_wr;
  item_t q_wdata;
  logic  q_full;
  logic  q_rd;
  item_t q_rdata;
  logic  q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version          <= VERSION_W'(1);
      cfg_r.mask_pattern     <= '0;
      cfg_r.data_codewords   <= '0;
      cfg_r.total_codewords  <= '0;
      cfg_r.blank_data       <= 1'b0;
      cfg_r.alignment_coords <= '0;
      cfg_r.alignment_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VERSION:      cfg_r.version          <= cfg_wdata[VERSION_W-1:0];
        CFG_MASK_PATTERN: cfg_r.mask_pattern     <= cfg_wdata[MASK_W-1:0];
        CFG_DATA_CW:      cfg_r.data_codewords   <= cfg_wdata[CW_W-1:0];
        CFG_TOTAL_CW:     cfg_r.total_codewords  <= cfg_wdata[CW_W-1:0];
        CFG_BLANK_DATA:   cfg_r.blank_data       <= cfg_wdata[0];
        CFG_ALIGN_COORDS: cfg_r.alignment_coords <= cfg_wdata;
        CFG_ALIGN_COUNT:  cfg_r.alignment_count  <= cfg_wdata[ACNT_W-1:0];
        default: ;
      endcase
    end
  end

  qpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  qpm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  qpm_walker #(
    .MAX_VERSION      (MAX_VERSION),
    .MAX_ALIGN_COORDS (MAX_ALIGN_COORDS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_rd       (q_rd),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/qpm_front.sv @@
// ----------------------------------------------------------------------------
// qpm_front
// Accepts codeword bytes, assigns the zone and the unmasked bits from the
// running codeword index, and pushes them into the work queue.
// ----------------------------------------------------------------------------
module qpm_front
  import qpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] codeword
  output logic                  q_wr,
  output item_t                 q_wdata,
  input  logic                  q_full
);

  logic [CW_W-1:0] cw_count_r;
  logic [CW_W-1:0] cw_count_nxt;

  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full;

  always_comb begin
    if (cw_count_r < cfg.data_codewords) begin
      q_wdata.zone = ZONE_DATA;
    end else if (cw_count_r < cfg.total_codewords) begin
      q_wdata.zone = ZONE_ECC;
    end else begin
      q_wdata.zone = ZONE_REM;
    end
    if (cw_count_r < cfg.total_codewords && !cfg.blank_data) begin
      q_wdata.bits = in_tdata[7:0];
    end else begin
      q_wdata.bits = 8'd0;
    end
    cw_count_nxt = (&cw_count_r) ? cw_count_r : cw_count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_count_r <= '0;
    end else if (q_wr) begin
      cw_count_r <= cw_count_nxt;
    end
  end

endmodule

@@ rtl/qpm_queue.sv @@
// ----------------------------------------------------------------------------
// qpm_queue
// Two-entry queue between the classifier and the placement walker.
// ----------------------------------------------------------------------------
module qpm_queue
  import qpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  empty
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ rtl/qpm_func_map.sv @@
// ----------------------------------------------------------------------------
// qpm_func_map
// Classifies the cursor module as function or data area: bounds, finders
// with format areas, timing lines, alignment patterns and version areas.
// ----------------------------------------------------------------------------
module qpm_func_map
  import qpm_pkg::*;
#(
  parameter int MAX_VERSION      = MaxVersionDef,
  parameter int MAX_ALIGN_COORDS = MaxAlignDef
) (
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] pair_col,
  input  logic               left_half,
  input  logic [COORD_W-1:0] row,
  output fmap_t              fm
);

  logic [VERSION_W-1:0]  ver;
  logic [COORD_W-1:0]    col;
  logic                  col_ok;
  logic [COORD_W:0]      n9;
  logic [COORD_W:0]      c9;
  logic [COORD_W:0]      r9;
  logic [ACNT_W-1:0]     cnt;
  logic [ACNT_W-1:0]     cnt_m1;
  logic [MAX_ALIGN_COORDS-1:0] chit;
  logic [MAX_ALIGN_COORDS-1:0] rhit;
  logic                  align;
  logic                  out_rng;
  logic                  finder;
  logic                  timing;
  logic                  ver_area;
  logic [COORD_W:0]      ac9;

  always_comb begin
    ver = cfg.version;
    if (ver == '0) begin
      ver = VERSION_W'(1);
    end else if (ver > VERSION_W'(MAX_VERSION)) begin
      ver = VERSION_W'(MAX_VERSION);
    end
    fm.side = COORD_W'(8'd17 + {ver, 2'b00});
    n9      = {1'b0, fm.side};
    col     = pair_col - {{(COORD_W-1){1'b0}}, left_half};
    col_ok  = !(pair_col == '0 && left_half);
    c9      = {1'b0, col};
    r9      = {1'b0, row};

    cnt = (cfg.alignment_count > ACNT_W'(MAX_ALIGN_COORDS)) ?
          ACNT_W'(MAX_ALIGN_COORDS) : cfg.alignment_count;
    cnt_m1 = cnt - 1'b1;
    for (int i = 0; i < MAX_ALIGN_COORDS; i++) begin
      ac9     = {1'b0, cfg.alignment_coords[8*i +: 8]};
      chit[i] = (ACNT_W'(i) < cnt) && (c9 + 9'd3 > ac9) && (c9 < ac9 + 9'd3);
      rhit[i] = (ACNT_W'(i) < cnt) && (r9 + 9'd3 > ac9) && (r9 < ac9 + 9'd3);
    end
    align = 1'b0;
    for (int i = 0; i < MAX_ALIGN_COORDS; i++) begin
      for (int j = 0; j < MAX_ALIGN_COORDS; j++) begin
        if (chit[i] && rhit[j] &&
            !((i == 0 && j == 0) ||
              (i == 0 && ACNT_W'(j) == cnt_m1) ||
              (ACNT_W'(i) == cnt_m1 && j == 0))) begin
          align = 1'b1;
        end
      end
    end

    out_rng  = !col_ok || (c9 >= n9) || (r9 >= n9);
    finder   = (c9 < 9'd9 && (r9 < 9'd9 || r9 + 9'd9 > n9)) ||
               (c9 + 9'd9 > n9 && r9 < 9'd9);
    timing   = (col == 8'd6) || (row == 8'd6);
    ver_area = (ver >= VERSION_W'(7)) &&
               ((c9 < 9'd6 && r9 + 9'd12 > n9) || (r9 < 9'd6 && c9 + 9'd12 > n9));
    fm.is_func = out_rng || finder || align || timing || ver_area;
  end

endmodule

@@ rtl/qpm_walker.sv @@
// ----------------------------------------------------------------------------
// qpm_walker
// Zigzag cursor: steps one candidate module per cycle unless the output stalls,
// places queued codewords MSB first, masks the bits and drives the result register.
// ----------------------------------------------------------------------------
module qpm_walker
  import qpm_pkg::*;
#(
  parameter int MAX_VERSION      = MaxVersionDef,
  parameter int MAX_ALIGN_COORDS = MaxAlignDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  output logic                   q_rd,
  input  item_t                  q_rdata,
  input  logic                   q_empty,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] column, [15:8] row, [16] dark,
                                             // [18:17] zone, zeros above
  output logic                   out_tlast,  // last_of_run
  output logic                   out_tuser   // matrix_done
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEEK, ST_NEXT} state_t;

  state_t             state_r;
  logic [COORD_W-1:0] pair_r;
  logic [COORD_W-1:0] row_r;
  logic               up_r;
  logic               left_r;
  logic               started_r;
  logic               finished_r;
  logic [2:0]         bit_r;
  logic [7:0]         bits_r;
  zone_t              zone_r;
  logic [COORD_W-1:0] pend_col_r;
  logic [COORD_W-1:0] pend_row_r;
  logic               pend_dark_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_col_r;
  logic [COORD_W-1:0] out_row_r;
  logic               out_dark_r;
  zone_t              out_zone_r;
  logic               out_last_r;
  logic               out_done_r;

  fmap_t              fm;
  logic [COORD_W-1:0] cur_col;
  logic               cur_mask;
  logic [2:0]         nxt_bit;
  logic               out_free;
  logic               last_mod;
  logic               emit;
  logic [COORD_W-1:0] adv_pair_nxt;
  logic [COORD_W-1:0] adv_row_nxt;
  logic               adv_up_nxt;
  logic               adv_left_nxt;
  logic               adv_fin_nxt;
  logic               adv_turn;

  qpm_func_map #(
    .MAX_VERSION      (MAX_VERSION),
    .MAX_ALIGN_COORDS (MAX_ALIGN_COORDS)
  ) u_func_map (
    .cfg       (cfg),
    .pair_col  (pair_r),
    .left_half (left_r),
    .row       (row_r),
    .fm        (fm)
  );

  assign cur_col  = pair_r - {{(COORD_W-1){1'b0}}, left_r};
  assign cur_mask = mask_bit(cfg.mask_pattern, cur_col, row_r);
  assign nxt_bit  = bit_r - 3'd1;
  assign out_free = !out_valid_r || out_tready;
  assign last_mod = (bit_r == 3'd0) || finished_r;
  assign q_rd     = (state_r == ST_IDLE) && !q_empty;
  assign emit     = (state_r == ST_NEXT) && (finished_r || !fm.is_func) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_zone_r, out_dark_r, out_row_r, out_col_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // one cursor step: right half -> left half -> next row, turn at the edge
  always_comb begin
    adv_pair_nxt = pair_r;
    adv_row_nxt  = row_r;
    adv_up_nxt   = up_r;
    adv_left_nxt = left_r;
    adv_fin_nxt  = finished_r;
    adv_turn     = 1'b0;
    if (!left_r) begin
      adv_left_nxt = 1'b1;
    end else begin
      adv_left_nxt = 1'b0;
      if (up_r) begin
        if (row_r == '0) begin
          adv_turn = 1'b1;
        end else begin
          adv_row_nxt = row_r - 1'b1;
        end
      end else begin
        if (row_r >= fm.side - 1'b1) begin
          adv_turn = 1'b1;
        end else begin
          adv_row_nxt = row_r + 1'b1;
        end
      end
      if (adv_turn) begin
        if (pair_r < COORD_W'(3)) begin
          adv_fin_nxt = 1'b1;
        end else begin
          adv_pair_nxt = (pair_r == COORD_W'(8)) ? COORD_W'(5) : pair_r - COORD_W'(2);
          adv_up_nxt   = !up_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pair_r      <= '0;
      row_r       <= '0;
      up_r        <= 1'b1;
      left_r      <= 1'b0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_rd) begin
            bits_r <= q_rdata.bits;
            zone_r <= q_rdata.zone;
            bit_r  <= 3'd7;
            if (!started_r) begin
              pair_r    <= fm.side - 1'b1;
              row_r     <= fm.side - 1'b1;
              up_r      <= 1'b1;
              left_r    <= 1'b0;
              started_r <= 1'b1;
            end
            if (!finished_r) begin
              state_r <= ST_SEEK;
            end
          end
        end
        ST_SEEK: begin
          if (finished_r) begin
            state_r <= ST_IDLE;
          end else begin
            if (!fm.is_func) begin
              pend_col_r  <= cur_col;
              pend_row_r  <= row_r;
              pend_dark_r <= bits_r[bit_r] ^ cur_mask;
              state_r     <= ST_NEXT;
            end
            pair_r     <= adv_pair_nxt;
            row_r      <= adv_row_nxt;
            up_r       <= adv_up_nxt;
            left_r     <= adv_left_nxt;
            finished_r <= adv_fin_nxt;
          end
        end
        ST_NEXT: begin
          if (!finished_r && fm.is_func) begin
            pair_r     <= adv_pair_nxt;
            row_r      <= adv_row_nxt;
            up_r       <= adv_up_nxt;
            left_r     <= adv_left_nxt;
            finished_r <= adv_fin_nxt;
          end else if (out_free) begin
            out_col_r   <= pend_col_r;
            out_row_r   <= pend_row_r;
            out_dark_r  <= pend_dark_r;
            out_zone_r  <= zone_r;
            out_last_r  <= last_mod;
            out_done_r  <= finished_r;
            if (last_mod) begin
              state_r <= ST_IDLE;
            end else begin
              // cursor already rests on a data module: take it right away
              bit_r       <= nxt_bit;
              pend_col_r  <= cur_col;
              pend_row_r  <= row_r;
              pend_dark_r <= bits_r[nxt_bit] ^ cur_mask;
              pair_r      <= adv_pair_nxt;
              row_r       <= adv_row_nxt;
              up_r        <= adv_up_nxt;
              left_r      <= adv_left_nxt;
              finished_r  <= adv_fin_nxt;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("matrix_done without last_of_run");

  a_finish_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("walk_finished cleared");

  a_next_started: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NEXT || finished_r |-> started_r)
    else $error("walk active before start");

  a_seek_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEEK && finished_r |=> state_r == ST_IDLE)
    else $error("seek did not stop at end of walk");

endmodule
